@@ rtl/core/heightmap_vertex_attributes_assert.svh @@
// ----------------------------------------------------------------------------
// Heightmap vertex attributes - assertion macros
// Shared property forms used by the block checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_ATTRIBUTES_ASSERT_SVH
`define HEIGHTMAP_VERTEX_ATTRIBUTES_ASSERT_SVH

// expression holds on every clock out of reset
`define HVA_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define HVA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent a fixed number of cycles later
`define HVA_ASSERT_DELAY(label, clk, rstn, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##n (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/hva_pkg.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex attributes - package
// Widths, pipeline depths and the side-band record of the vertex pipeline.
// ----------------------------------------------------------------------------
package hva_pkg;

    localparam int HVA_GRID_POINTS = 256;
    localparam int HVA_UNIT_ONE    = 16384;

    localparam int HVA_MAG_W  = 17;
    localparam int HVA_SQ_W   = 2 * HVA_MAG_W;
    localparam int HVA_LEN_W  = HVA_SQ_W + 1;
    localparam int HVA_REM_W  = HVA_LEN_W + 1;
    localparam int HVA_QUO_W  = 31;
    localparam int HVA_RAD_W  = HVA_QUO_W + 1;
    localparam int HVA_ROOT_W = HVA_RAD_W / 2;
    localparam int HVA_SRM_W  = HVA_ROOT_W + 3;
    localparam int HVA_UNIT_W = 15;

    localparam int HVA_DIV_N    = HVA_QUO_W;
    localparam int HVA_SQRT_N   = HVA_ROOT_W;
    localparam int HVA_NORM_LAT = HVA_DIV_N + HVA_SQRT_N + 1;

    // input, square and sum stages, the unit, then sign, product and round
    localparam int HVA_SIDE_LEN = 3 + HVA_NORM_LAT + 3;
    localparam int HVA_LAT      = HVA_SIDE_LEN;

    typedef enum logic [1:0] {
        CFG_COL_PITCH = 2'd0,
        CFG_ROW_PITCH = 2'd1,
        CFG_UV_STEP   = 2'd2,
        CFG_TEX_SPAN  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        vld;
        logic [23:0] pos_x;
        logic [15:0] pos_y;
        logic [23:0] pos_z;
        logic [23:0] tex_u;
        logic [15:0] tex_v;
        logic        neg_ty;
        logic        neg_by;
    } t_side;

endpackage

@@ rtl/core/hva_norm.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex attributes - unit component pipeline
// round(16384 * sqrt(mag2 / len2)): restoring divide, one bit a stage, then
// restoring square root, one digit a stage, then halve with rounding.
// ----------------------------------------------------------------------------
module hva_norm (
    input  logic                            i_clk,
    input  logic [hva_pkg::HVA_SQ_W-1:0]    i_mag2,
    input  logic [hva_pkg::HVA_LEN_W-1:0]   i_len2,
    output logic [hva_pkg::HVA_UNIT_W-1:0]  o_q
);
    import hva_pkg::*;

    // divider chain
    logic [HVA_REM_W-1:0] w_drem [0:HVA_DIV_N];
    logic [HVA_LEN_W-1:0] w_dlen [0:HVA_DIV_N];
    logic [HVA_QUO_W-1:0] w_dquo [0:HVA_DIV_N];
    logic                 w_dzer [0:HVA_DIV_N];

    assign w_drem[0] = HVA_REM_W'(i_mag2);
    assign w_dlen[0] = i_len2;
    assign w_dquo[0] = '0;
    assign w_dzer[0] = (i_len2 == '0);

    for (genvar j = 0; j < HVA_DIV_N; j++) begin : g_div
        logic [HVA_REM_W-1:0] r_rem;
        logic [HVA_LEN_W-1:0] r_len;
        logic [HVA_QUO_W-1:0] r_quo;
        logic                 r_zer;
        logic                 n_ge;
        logic [HVA_REM_W-1:0] n_rem;

        always_comb begin
            n_ge  = (w_drem[j] >= HVA_REM_W'(w_dlen[j]));
            n_rem = n_ge ? (w_drem[j] - HVA_REM_W'(w_dlen[j])) : w_drem[j];
        end

        always_ff @(posedge i_clk) begin
            r_rem <= {n_rem[HVA_REM_W-2:0], 1'b0};
            r_len <= w_dlen[j];
            r_quo <= {w_dquo[j][HVA_QUO_W-2:0], n_ge};
            r_zer <= w_dzer[j];
        end

        assign w_drem[j+1] = r_rem;
        assign w_dlen[j+1] = r_len;
        assign w_dquo[j+1] = r_quo;
        assign w_dzer[j+1] = r_zer;
    end

    // square root chain
    logic [HVA_SRM_W-1:0]  w_srem [0:HVA_SQRT_N];
    logic [HVA_ROOT_W-1:0] w_root [0:HVA_SQRT_N];
    logic [HVA_RAD_W-1:0]  w_rad  [0:HVA_SQRT_N];
    logic                  w_szer [0:HVA_SQRT_N];

    assign w_srem[0] = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = HVA_RAD_W'(w_dquo[HVA_DIV_N]);
    assign w_szer[0] = w_dzer[HVA_DIV_N];

    for (genvar k = 0; k < HVA_SQRT_N; k++) begin : g_sqrt
        logic [HVA_SRM_W-1:0]  r_rem;
        logic [HVA_ROOT_W-1:0] r_root;
        logic [HVA_RAD_W-1:0]  r_rad;
        logic                  r_zer;
        logic [HVA_SRM_W-1:0]  n_sh;
        logic [HVA_SRM_W-1:0]  n_trial;
        logic                  n_ge;

        always_comb begin
            n_sh    = {w_srem[k][HVA_SRM_W-3:0], w_rad[k][HVA_RAD_W-1 -: 2]};
            n_trial = {1'b0, w_root[k], 2'b01};
            n_ge    = (n_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_ge ? (n_sh - n_trial) : n_sh;
            r_root <= {w_root[k][HVA_ROOT_W-2:0], n_ge};
            r_rad  <= {w_rad[k][HVA_RAD_W-3:0], 2'b00};
            r_zer  <= w_szer[k];
        end

        assign w_srem[k+1] = r_rem;
        assign w_root[k+1] = r_root;
        assign w_rad[k+1]  = r_rad;
        assign w_szer[k+1] = r_zer;
    end

    // halve with rounding
    logic [HVA_UNIT_W-1:0]  r_q;
    logic [HVA_ROOT_W:0]    n_sum;
    logic [HVA_ROOT_W-1:0]  n_half;
    logic [HVA_UNIT_W-1:0]  n_q;

    always_comb begin
        n_sum  = {1'b0, w_root[HVA_SQRT_N]} + (HVA_ROOT_W+1)'(1);
        n_half = n_sum[HVA_ROOT_W:1];
        if (w_szer[HVA_SQRT_N]) begin
            n_q = '0;
        end else if (n_half > HVA_ROOT_W'(HVA_UNIT_ONE)) begin
            n_q = HVA_UNIT_W'(HVA_UNIT_ONE);
        end else begin
            n_q = n_half[HVA_UNIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ rtl/core/heightmap_vertex_attributes.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex attributes
// Per-vertex position, texture coordinates and central-difference tangent frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with one vertex (col, row and five heights) on the inputs; it
//   is taken at that clock edge. busy is never raised, so a vertex may be
//   presented in every cycle.
//   Each vertex yields one result, shown for exactly one cycle with o_valid,
//   in order. Throughput is one vertex a cycle.
//   Latency is set by the unit-vector pipelines: a 31-stage restoring divider
//   and a 16-stage square root, one bit or digit per stage, plus input,
//   square, sum, sign, product and rounding stages.
//   The four step registers are written by i_cfg_we / i_cfg_idx / i_cfg_data
//   at any edge; write them only while no vertex is in flight.
//   Reset (synchronous, active low) empties the pipeline and sets all four
//   registers to 1.0 (Q8.8). Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module heightmap_vertex_attributes (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  hva_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    input  logic signed [15:0] i_h_center,
    input  logic signed [15:0] i_h_left,
    input  logic signed [15:0] i_h_right,
    input  logic signed [15:0] i_h_up,
    input  logic signed [15:0] i_h_down,
    output logic               o_valid,
    output logic [23:0]        o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic [23:0]        o_pos_z,
    output logic [23:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [14:0]        o_tangent_x,
    output logic signed [15:0] o_tangent_y,
    output logic signed [15:0] o_bitangent_y,
    output logic [14:0]        o_bitangent_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z
);
    import hva_pkg::*;

    // round Q2.28 product to Q1.14, ties away from zero, optionally negated
    function automatic logic signed [15:0] round_q14(input logic signed [31:0] p,
                                                     input logic neg);
        logic [31:0] mag;
        logic [31:0] sum;
        logic [15:0] r;
        mag = p[31] ? 32'(-p) : 32'(p);
        sum = mag + 32'd8192;
        r   = sum[29:14];
        return (p[31] ^ neg) ? 16'(-r) : 16'(r);
    endfunction

    // configuration
    logic [15:0] r_col_pitch;
    logic [15:0] r_row_pitch;
    logic [15:0] r_uv_step;
    logic [15:0] r_tex_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pitch <= 16'd256;
            r_row_pitch <= 16'd256;
            r_uv_step   <= 16'd256;
            r_tex_span  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COL_PITCH: r_col_pitch <= i_cfg_data;
                CFG_ROW_PITCH: r_row_pitch <= i_cfg_data;
                CFG_UV_STEP:   r_uv_step   <= i_cfg_data;
                CFG_TEX_SPAN:  r_tex_span  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: index clamp, positions, texture, differences
    logic [7:0]  n_col;
    logic [7:0]  n_row;
    logic [23:0] n_vsub;
    t_side       n_side;
    logic signed [HVA_MAG_W-1:0] n_dy_t;
    logic signed [HVA_MAG_W-1:0] n_dy_b;

    always_comb begin
        n_col = (int'(i_col) >= HVA_GRID_POINTS) ? 8'(HVA_GRID_POINTS - 1) : i_col;
        n_row = (int'(i_row) >= HVA_GRID_POINTS) ? 8'(HVA_GRID_POINTS - 1) : i_row;
        n_vsub = 24'(n_row) * 24'(r_uv_step);
        n_dy_t = HVA_MAG_W'(i_h_right) - HVA_MAG_W'(i_h_left);
        n_dy_b = HVA_MAG_W'(i_h_up) - HVA_MAG_W'(i_h_down);
        n_side.vld    = start;
        n_side.pos_x  = 24'(n_col) * 24'(r_col_pitch);
        n_side.pos_y  = i_h_center;
        n_side.pos_z  = 24'(n_row) * 24'(r_row_pitch);
        n_side.tex_u  = 24'(n_col) * 24'(r_uv_step);
        n_side.tex_v  = (24'(r_tex_span) > n_vsub) ? 16'(24'(r_tex_span) - n_vsub)
                                                   : 16'd0;
        n_side.neg_ty = n_dy_t[HVA_MAG_W-1];
        n_side.neg_by = n_dy_b[HVA_MAG_W-1];
    end

    t_side r_side [0:HVA_SIDE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HVA_SIDE_LEN; i++) begin
                r_side[i].vld <= 1'b0;
            end
        end else begin
            r_side[0].vld <= n_side.vld;
            for (int i = 1; i < HVA_SIDE_LEN; i++) begin
                r_side[i].vld <= r_side[i-1].vld;
            end
        end
        r_side[0][$bits(t_side)-2:0] <= n_side[$bits(t_side)-2:0];
        for (int i = 1; i < HVA_SIDE_LEN; i++) begin
            r_side[i][$bits(t_side)-2:0] <= r_side[i-1][$bits(t_side)-2:0];
        end
    end

    logic [HVA_MAG_W-1:0]        r1_ax;
    logic signed [HVA_MAG_W-1:0] r1_ay;
    logic signed [HVA_MAG_W-1:0] r1_bx;
    logic [HVA_MAG_W-1:0]        r1_bz;

    always_ff @(posedge i_clk) begin
        r1_ax <= {r_col_pitch, 1'b0};
        r1_ay <= n_dy_t;
        r1_bx <= n_dy_b;
        r1_bz <= {r_row_pitch, 1'b0};
    end

    // stage 2: squares
    logic [HVA_MAG_W-1:0] n_may;
    logic [HVA_MAG_W-1:0] n_mbx;
    logic [HVA_SQ_W-1:0]  r2_sq_tx;
    logic [HVA_SQ_W-1:0]  r2_sq_ty;
    logic [HVA_SQ_W-1:0]  r2_sq_by;
    logic [HVA_SQ_W-1:0]  r2_sq_bz;

    always_comb begin
        n_may = r1_ay[HVA_MAG_W-1] ? HVA_MAG_W'(-r1_ay) : HVA_MAG_W'(r1_ay);
        n_mbx = r1_bx[HVA_MAG_W-1] ? HVA_MAG_W'(-r1_bx) : HVA_MAG_W'(r1_bx);
    end

    always_ff @(posedge i_clk) begin
        r2_sq_tx <= HVA_SQ_W'(r1_ax) * HVA_SQ_W'(r1_ax);
        r2_sq_ty <= HVA_SQ_W'(n_may) * HVA_SQ_W'(n_may);
        r2_sq_by <= HVA_SQ_W'(n_mbx) * HVA_SQ_W'(n_mbx);
        r2_sq_bz <= HVA_SQ_W'(r1_bz) * HVA_SQ_W'(r1_bz);
    end

    // stage 3: squared lengths
    logic [HVA_SQ_W-1:0]  r3_sq_tx;
    logic [HVA_SQ_W-1:0]  r3_sq_ty;
    logic [HVA_SQ_W-1:0]  r3_sq_by;
    logic [HVA_SQ_W-1:0]  r3_sq_bz;
    logic [HVA_LEN_W-1:0] r3_len_t;
    logic [HVA_LEN_W-1:0] r3_len_b;

    always_ff @(posedge i_clk) begin
        r3_sq_tx <= r2_sq_tx;
        r3_sq_ty <= r2_sq_ty;
        r3_sq_by <= r2_sq_by;
        r3_sq_bz <= r2_sq_bz;
        r3_len_t <= HVA_LEN_W'(r2_sq_tx) + HVA_LEN_W'(r2_sq_ty);
        r3_len_b <= HVA_LEN_W'(r2_sq_by) + HVA_LEN_W'(r2_sq_bz);
    end

    // unit components
    logic [HVA_UNIT_W-1:0] w_q_tx;
    logic [HVA_UNIT_W-1:0] w_q_ty;
    logic [HVA_UNIT_W-1:0] w_q_by;
    logic [HVA_UNIT_W-1:0] w_q_bz;

    hva_norm u_norm_tx (
        .i_clk   (i_clk),
        .i_mag2  (r3_sq_tx),
        .i_len2  (r3_len_t),
        .o_q     (w_q_tx)
    );

    hva_norm u_norm_ty (
        .i_clk   (i_clk),
        .i_mag2  (r3_sq_ty),
        .i_len2  (r3_len_t),
        .o_q     (w_q_ty)
    );

    hva_norm u_norm_by (
        .i_clk   (i_clk),
        .i_mag2  (r3_sq_by),
        .i_len2  (r3_len_b),
        .o_q     (w_q_by)
    );

    hva_norm u_norm_bz (
        .i_clk   (i_clk),
        .i_mag2  (r3_sq_bz),
        .i_len2  (r3_len_b),
        .o_q     (w_q_bz)
    );

    localparam int SgnIdx = 3 + HVA_NORM_LAT;

    // sign stage
    logic [14:0]        r4_tx;
    logic signed [15:0] r4_ty;
    logic signed [15:0] r4_by;
    logic [14:0]        r4_bz;

    always_ff @(posedge i_clk) begin
        r4_tx <= w_q_tx;
        r4_ty <= r_side[SgnIdx-1].neg_ty ? 16'(-{1'b0, w_q_ty}) : 16'({1'b0, w_q_ty});
        r4_by <= r_side[SgnIdx-1].neg_by ? 16'(-{1'b0, w_q_by}) : 16'({1'b0, w_q_by});
        r4_bz <= w_q_bz;
    end

    // product stage
    logic [14:0]        r5_tx;
    logic signed [15:0] r5_ty;
    logic signed [15:0] r5_by;
    logic [14:0]        r5_bz;
    logic signed [31:0] r5_p_nx;
    logic signed [31:0] r5_p_ny;
    logic signed [31:0] r5_p_nz;

    always_ff @(posedge i_clk) begin
        r5_tx   <= r4_tx;
        r5_ty   <= r4_ty;
        r5_by   <= r4_by;
        r5_bz   <= r4_bz;
        r5_p_nx <= $signed(32'({1'b0, r4_bz})) * 32'(r4_ty);
        r5_p_ny <= $signed(32'({1'b0, r4_bz})) * $signed(32'({1'b0, r4_tx}));
        r5_p_nz <= 32'(r4_by) * $signed(32'({1'b0, r4_tx}));
    end

    // rounding stage
    logic [14:0]        r6_tx;
    logic signed [15:0] r6_ty;
    logic signed [15:0] r6_by;
    logic [14:0]        r6_bz;
    logic signed [15:0] r6_nx;
    logic signed [15:0] r6_ny;
    logic signed [15:0] r6_nz;

    always_ff @(posedge i_clk) begin
        r6_tx <= r5_tx;
        r6_ty <= r5_ty;
        r6_by <= r5_by;
        r6_bz <= r5_bz;
        r6_nx <= round_q14(r5_p_nx, 1'b1);
        r6_ny <= round_q14(r5_p_ny, 1'b0);
        r6_nz <= round_q14(r5_p_nz, 1'b1);
    end

    assign o_valid       = r_side[HVA_SIDE_LEN-1].vld;
    assign o_pos_x       = r_side[HVA_SIDE_LEN-1].pos_x;
    assign o_pos_y       = r_side[HVA_SIDE_LEN-1].pos_y;
    assign o_pos_z       = r_side[HVA_SIDE_LEN-1].pos_z;
    assign o_tex_u       = r_side[HVA_SIDE_LEN-1].tex_u;
    assign o_tex_v       = r_side[HVA_SIDE_LEN-1].tex_v;
    assign o_tangent_x   = r6_tx;
    assign o_tangent_y   = r6_ty;
    assign o_bitangent_y = r6_by;
    assign o_bitangent_z = r6_bz;
    assign o_normal_x    = r6_nx;
    assign o_normal_y    = r6_ny;
    assign o_normal_z    = r6_nz;

endmodule

@@ rtl/core/hva_checker.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex attributes - port checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
`include "heightmap_vertex_attributes_assert.svh"

module hva_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [14:0]        o_tangent_x,
    input logic signed [15:0] o_tangent_y,
    input logic [14:0]        o_bitangent_z,
    input logic signed [15:0] o_normal_y
);
    import hva_pkg::*;

    `HVA_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)
    `HVA_ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, HVA_LAT, o_valid)
    `HVA_ASSERT_IMP(a_unit_range, i_clk, i_rst_n, o_valid, o_tangent_x <= 15'd16384 && o_bitangent_z <= 15'd16384 && o_tangent_y <= 16'sd16384 && o_tangent_y >= -16'sd16384)
    `HVA_ASSERT_IMP(a_normal_y_sign, i_clk, i_rst_n, o_valid, o_normal_y >= 16'sd0)

endmodule

bind heightmap_vertex_attributes hva_checker u_hva_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_tangent_x   (o_tangent_x),
    .o_tangent_y   (o_tangent_y),
    .o_bitangent_z (o_bitangent_z),
    .o_normal_y    (o_normal_y)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Heightmap vertex attributes - testbench
// Drives vertices through the command port with random gaps and checks every
// result against a cycle-free predictor of position, texture and tangent frame.
// ----------------------------------------------------------------------------
import hva_pkg::*;

typedef struct {
    logic [23:0] pos_x;
    logic [15:0] pos_y;
    logic [23:0] pos_z;
    logic [23:0] tex_u;
    logic [15:0] tex_v;
    logic [14:0] tangent_x;
    logic [15:0] tangent_y;
    logic [15:0] bitangent_y;
    logic [14:0] bitangent_z;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
} vertex_attr_t;

class vertex_scoreboard;
    logic [15:0]  col_pitch, row_pitch, uv_step, tex_span;
    vertex_attr_t pending[$];
    int           errors;

    function new();
        col_pitch = 16'd256;
        row_pitch = 16'd256;
        uv_step   = 16'd256;
        tex_span  = 16'd256;
        errors    = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [15:0] val);
        case (idx)
            CFG_COL_PITCH: col_pitch = val;
            CFG_ROW_PITCH: row_pitch = val;
            CFG_UV_STEP:   uv_step = val;
            CFG_TEX_SPAN:  tex_span = val;
        endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint unit_component(longint c, longint unsigned len2);
        longint unsigned m, n, q;
        m = (c < 0) ? -c : c;
        n = 64'd16384 * m;
        q = (int_sqrt((64'd4 * n * n) / len2) + 1) / 2;
        if (q > 16384) q = 16384;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void unit_pair(longint a, longint b, output longint ua, output longint ub);
        longint unsigned len2;
        len2 = a * a + b * b;
        if (len2 == 0) begin
            ua = 0;
            ub = 0;
        end else begin
            ua = unit_component(a, len2);
            ub = unit_component(b, len2);
        end
    endfunction

    function longint round_q14(longint x, longint y);
        longint p, r;
        p = x * y;
        r = (((p < 0) ? -p : p) + 8192) >>> 14;
        return (p < 0) ? -r : r;
    endfunction

    function void note_vertex(logic [7:0] col, logic [7:0] row, logic signed [15:0] hc,
                              logic signed [15:0] hl, logic signed [15:0] hr,
                              logic signed [15:0] hu, logic signed [15:0] hd);
        vertex_attr_t a;
        longint       tx, ty, by, bz;
        longint unsigned vsub;
        vsub = longint'(row) * uv_step;
        unit_pair(2 * longint'(col_pitch), longint'(hr) - longint'(hl), tx, ty);
        unit_pair(longint'(hu) - longint'(hd), 2 * longint'(row_pitch), by, bz);
        a.pos_x       = col * col_pitch;
        a.pos_y       = hc;
        a.pos_z       = row * row_pitch;
        a.tex_u       = col * uv_step;
        a.tex_v       = (tex_span > vsub) ? tex_span - vsub : 16'd0;
        a.tangent_x   = tx[14:0];
        a.tangent_y   = ty[15:0];
        a.bitangent_y = by[15:0];
        a.bitangent_z = bz[14:0];
        a.normal_x    = 16'(-round_q14(bz, ty));
        a.normal_y    = 16'(round_q14(bz, tx));
        a.normal_z    = 16'(-round_q14(by, tx));
        pending.push_back(a);
    endfunction

    function void cmp(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(vertex_attr_t act);
        vertex_attr_t e;
        if (pending.size() == 0) begin
            $error("result with no vertex outstanding");
            errors++;
            return;
        end
        e = pending.pop_front();
        cmp("pos_x", e.pos_x, act.pos_x);
        cmp("pos_y", e.pos_y, act.pos_y);
        cmp("pos_z", e.pos_z, act.pos_z);
        cmp("tex_u", e.tex_u, act.tex_u);
        cmp("tex_v", e.tex_v, act.tex_v);
        cmp("tangent_x", e.tangent_x, act.tangent_x);
        cmp("tangent_y", e.tangent_y, act.tangent_y);
        cmp("bitangent_y", e.bitangent_y, act.bitangent_y);
        cmp("bitangent_z", e.bitangent_z, act.bitangent_z);
        cmp("normal_x", e.normal_x, act.normal_x);
        cmp("normal_y", e.normal_y, act.normal_y);
        cmp("normal_z", e.normal_z, act.normal_z);
    endfunction
endclass

module testbench;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    t_cfg_idx           i_cfg_idx = CFG_COL_PITCH;
    logic [15:0]        i_cfg_data = '0;
    logic [7:0]         i_col = '0, i_row = '0;
    logic signed [15:0] i_h_center = '0, i_h_left = '0, i_h_right = '0;
    logic signed [15:0] i_h_up = '0, i_h_down = '0;
    logic               o_valid;
    logic [23:0]        o_pos_x, o_pos_z, o_tex_u;
    logic signed [15:0] o_pos_y;
    logic [15:0]        o_tex_v;
    logic [14:0]        o_tangent_x, o_bitangent_z;
    logic signed [15:0] o_tangent_y, o_bitangent_y;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;

    vertex_scoreboard sb = new();
    int               idle_cycles = 0;
    bit               accept_mode = 1'b0;

    localparam int WATCHDOG = 2000;

    heightmap_vertex_attributes dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        vertex_attr_t r;
        if (i_rst_n && o_valid) begin
            r.pos_x = o_pos_x;  r.pos_y = o_pos_y;  r.pos_z = o_pos_z;
            r.tex_u = o_tex_u;  r.tex_v = o_tex_v;
            r.tangent_x = o_tangent_x;  r.tangent_y = o_tangent_y;
            r.bitangent_y = o_bitangent_y;  r.bitangent_z = o_bitangent_z;
            r.normal_x = o_normal_x;  r.normal_y = o_normal_y;  r.normal_z = o_normal_z;
            sb.check_result(r);
        end
        if (i_rst_n && ((start && !busy) || o_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_steps(logic [15:0] w, logic [15:0] l, logic [15:0] u,
                             logic [15:0] d);
        write_reg(CFG_COL_PITCH, w);
        write_reg(CFG_ROW_PITCH, l);
        write_reg(CFG_UV_STEP, u);
        write_reg(CFG_TEX_SPAN, d);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (HVA_LAT + 4) @(negedge i_clk);
    endtask

    // caller is at a falling edge; holds start until the transfer is taken
    task automatic send_vertex(logic [7:0] col, logic [7:0] row, logic [15:0] hc,
                               logic [15:0] hl, logic [15:0] hr, logic [15:0] hu,
                               logic [15:0] hd, bit gaps);
        int gap;
        gap = (gaps && accept_mode) ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_col <= col;  i_row <= row;  i_h_center <= hc;
        i_h_left <= hl;  i_h_right <= hr;  i_h_up <= hu;  i_h_down <= hd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_vertex(col, row, hc, hl, hr, hu, hd);
        @(negedge i_clk);
    endtask

    task automatic send_random(int n);
        logic [15:0] hl, hr, hu, hd;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) accept_mode = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 3) == 0) begin
                hl = $urandom; hr = $urandom; hu = $urandom; hd = $urandom;
            end else begin
                hl = $urandom_range(0, 1023) - 512;
                hr = hl + $urandom_range(0, 511) - 256;
                hu = $urandom_range(0, 1023) - 512;
                hd = hu + $urandom_range(0, 511) - 256;
            end
            send_vertex($urandom, $urandom, $urandom, hl, hr, hu, hd, 1'b1);
        end
        start <= 1'b0;
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_vertex(8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_vertex(8'hFF, 8'hFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
        send_vertex(8'hFF, 8'h00, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0);
        send_vertex(8'h01, 8'h01, 16'hFFFF, 16'h0100, 16'h0300, 16'h0000, 16'h0200, 0);
        send_vertex(8'h80, 8'h7F, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 0);
        start <= 1'b0;
        wait_drained();

        // zero steps: zero-length and height-only differences
        set_steps(16'd0, 16'd0, 16'd0, 16'd0);
        send_vertex(8'd3, 8'd4, 16'h0010, 16'h0020, 16'h0020, 16'h0040, 16'h0040, 0);
        send_vertex(8'd3, 8'd4, 16'h0010, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 0);
        start <= 1'b0;
        wait_drained();

        set_steps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_vertex(8'hFF, 8'hFF, 16'h1234, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 0);
        send_vertex(8'h00, 8'h01, 16'h1234, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0);
        start <= 1'b0;
        wait_drained();

        // tex_v saturation and near-zero
        set_steps(16'd1, 16'd1, 16'd300, 16'd1000);
        send_vertex(8'd3, 8'd3, 16'h0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
        send_vertex(8'd4, 8'd4, 16'h0, 16'h0000, 16'h0001, 16'h0001, 16'h0000, 0);
        send_vertex(8'd0, 8'd200, 16'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        start <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0)
                set_steps(16'd256, 16'd256, 16'd256, 16'd256);
            else
                set_steps($urandom_range(1, 65535), $urandom_range(1, 65535),
                          $urandom, $urandom);
            send_random(210);
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
